>>> sv/cba_pkg.sv
package cba_pkg;

    localparam int CNT_W = 11;
    localparam int BLK_W = 10;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_REQ  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LINK,
        S_FREE_CHK,
        S_FREE_RD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             req_type;
        logic [CNT_W-1:0] blocks_wanted;
        logic [BLK_W-1:0] start_block;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [BLK_W-1:0] first_block;
        logic [CNT_W-1:0] free_blocks;
    } rsp_t;

endpackage

>>> sv/cba_mem.sv
module cba_mem
    import cba_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/cba_seq.sv
module cba_seq
    import cba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024,
    parameter int IW         = $clog2(MAX_BLOCKS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    input  logic [CNT_W-1:0] block_count,
    output logic             res_valid,
    input  logic             res_ready,
    output rsp_t             res,
    output logic             wr_en,
    output logic [IW-1:0]    wr_addr,
    output logic [IW:0]      wr_data,
    output logic [IW-1:0]    rd_addr,
    input  logic [IW:0]      rd_data
);

    localparam int VW = $clog2(MAX_BLOCKS + 1);

    state_t           state_reg, state_next;
    logic [IW-1:0]    clr_i_reg, clr_i_next;
    logic [CNT_W-1:0] scan_i_reg, scan_i_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IW-1:0]    chk_addr_reg, chk_addr_next;
    logic [CNT_W-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0] wanted_reg, wanted_next;
    logic [IW-1:0]    prev_reg, prev_next;
    logic             have_prev_reg, have_prev_next;
    logic [IW-1:0]    first_reg, first_next;
    logic [IW-1:0]    cur_reg, cur_next;
    logic [VW-1:0]    visits_reg, visits_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;
    status_t          status_reg, status_next;

    logic [CNT_W-1:0] free_left;
    logic             issue;
    logic             hit;
    logic             scan_done;
    logic             walk_done;
    logic [IW-1:0]    nxt;
    logic [VW-1:0]    visits_inc;

    assign free_left = (block_count > used_count_reg) ? (block_count - used_count_reg)
                                                      : '0;
    assign issue     = (scan_i_reg < block_count);
    assign hit       = chk_vld_reg && !rd_data[IW] && (taken_reg < wanted_reg);
    assign scan_done = (hit && (taken_reg + 1'b1 == wanted_reg))
                    || (!chk_vld_reg && !issue);
    assign nxt        = rd_data[IW-1:0];
    assign visits_inc = visits_reg + 1'b1;
    assign walk_done  = (nxt == cur_reg) || (32'(nxt) >= MAX_BLOCKS)
                     || (visits_inc == VW'(MAX_BLOCKS));

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.status      = status_reg;
        res.first_block = BLK_W'(first_reg);
        res.free_blocks = free_left;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_i_reg == IW'(MAX_BLOCKS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.req_type == REQ_ALLOC)
                    begin
                        if (req.blocks_wanted == '0 || free_left < req.blocks_wanted)
                            state_next = S_DONE;
                        else
                            state_next = S_SCAN;
                    end
                    else if (CNT_W'(req.start_block) >= block_count)
                        state_next = S_DONE;
                    else
                        state_next = S_FREE_RD;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                    state_next = S_LINK;
            end
            S_LINK:     state_next = S_DONE;
            S_FREE_RD:  state_next = S_FREE_CHK;
            S_FREE_CHK:
            begin
                if (walk_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        clr_i_next      = clr_i_reg;
        scan_i_next     = scan_i_reg;
        chk_vld_next    = 1'b0;
        chk_addr_next   = chk_addr_reg;
        taken_next      = taken_reg;
        wanted_next     = wanted_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        first_next      = first_reg;
        cur_next        = cur_reg;
        visits_next     = visits_reg;
        used_count_next = used_count_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_addr         = prev_reg;
        wr_data         = {1'b1, chk_addr_reg};
        rd_addr         = cur_reg;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = clr_i_reg;
                wr_data    = {1'b0, clr_i_reg};
                clr_i_next = clr_i_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    first_next     = '0;
                    status_next    = ST_OK;
                    wanted_next    = req.blocks_wanted;
                    scan_i_next    = '0;
                    taken_next     = '0;
                    have_prev_next = 1'b0;
                    cur_next       = IW'(req.start_block);
                    visits_next    = '0;
                    if (req.req_type == REQ_ALLOC)
                    begin
                        if (req.blocks_wanted == '0)
                            status_next = ST_BAD_REQ;
                        else if (free_left < req.blocks_wanted)
                            status_next = ST_NO_SPACE;
                    end
                    else if (CNT_W'(req.start_block) >= block_count)
                        status_next = ST_BAD_REQ;
                end
            end
            S_SCAN:
            begin
                // reads run one address ahead of the check
                rd_addr       = IW'(scan_i_reg);
                chk_vld_next  = issue && !scan_done;
                chk_addr_next = IW'(scan_i_reg);
                scan_i_next   = scan_i_reg + CNT_W'(issue);
                if (hit)
                begin
                    // link the previous block to this one
                    if (have_prev_reg)
                        wr_en = 1'b1;
                    else
                        first_next = chk_addr_reg;
                    prev_next      = chk_addr_reg;
                    have_prev_next = 1'b1;
                    taken_next     = taken_reg + 1'b1;
                end
            end
            S_LINK:
            begin
                wr_en           = have_prev_reg;
                wr_data         = {1'b1, prev_reg};
                used_count_next = used_count_reg + taken_reg;
            end
            S_FREE_RD:
            begin
                rd_addr = cur_reg;
            end
            S_FREE_CHK:
            begin
                rd_addr = nxt;
                wr_addr = cur_reg;
                wr_data = {1'b0, nxt};
                if (rd_data[IW])
                begin
                    wr_en = 1'b1;
                    if (used_count_reg != '0)
                        used_count_next = used_count_reg - 1'b1;
                end
                cur_next    = nxt;
                visits_next = visits_inc;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_i_reg      <= '0;
            chk_vld_reg    <= 1'b0;
            used_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_i_reg      <= clr_i_next;
            chk_vld_reg    <= chk_vld_next;
            used_count_reg <= used_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_i_reg    <= scan_i_next;
        chk_addr_reg  <= chk_addr_next;
        taken_reg     <= taken_next;
        wanted_reg    <= wanted_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        first_reg     <= first_next;
        cur_reg       <= cur_next;
        visits_reg    <= visits_next;
        status_reg    <= status_next;
    end

endmodule

>>> sv/chained_block_allocator.sv
// channel | direction | handshake             | carries
// req     | in        | req_valid/req_ready   | req_t: type, blocks wanted, start block
// rsp     | out       | rsp_valid/rsp_ready   | rsp_t: status, first block, free blocks
// cfg     | in        | cfg_valid/cfg_ready   | block_count write data
//
// One item at a time. Rejected requests go straight to the result stage.
// Allocate: one table read per cycle while scanning.
// Free: one chain link followed per cycle.
// After reset a clearing pass over all MAX_BLOCKS entries initializes the table;
// req_ready stays low until it ends. cfg is always ready.
// A result waits in the output register while the next item is taken.
module chained_block_allocator
    import cba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] BC_RESET =
        CNT_W'((MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024);

    logic [CNT_W-1:0] block_count_reg, block_count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             res_valid;
    logic             res_ready;
    rsp_t             res;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [IW:0]      wr_data;
    logic [IW-1:0]    rd_addr;
    logic [IW:0]      rd_data;

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        block_count_next = block_count_reg;
        if (cfg_valid)
        begin
            if (cfg_data == '0)
                block_count_next = CNT_W'(1);
            else if (32'(cfg_data) > MAX_BLOCKS)
                block_count_next = CNT_W'(MAX_BLOCKS);
            else
                block_count_next = cfg_data;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BC_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            block_count_reg <= block_count_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    cba_seq #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IW         (IW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .block_count (block_count_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    // entry: {used, next block}
    cba_mem #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW),
        .DW    (IW + 1)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

>>> sv/cba_checker.sv
module cba_checker
    import cba_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input rsp_t             rsp,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [CNT_W-1:0] cfg_data
);

    logic req_fire;
    logic cfg_fire;

    assign req_fire = req_valid && req_ready;
    assign cfg_fire = cfg_valid && cfg_ready;

    // one item in flight: busy right after taking one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("req_ready high in the cycle after an item was taken");

    // the result passes the done state and then the output register, so no result appears right after accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !$rose(rsp_valid))
        else $error("result appeared one cycle after accept");

    a_failed_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.first_block == '0))
        else $error("failed request reports a first block");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result dropped or changed");

    a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |-> !$isunknown(cfg_data))
        else $error("configuration write with unknown data");

endmodule

bind chained_block_allocator cba_checker u_cba_checker (.*);
